// ===== design/assert_macros.svh =====
// Assertion macros for the checker file, fsc_checker.
// Each macro samples on clk_i and is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

// ===== design/fsc_pkg.sv =====
// Shared types and constants for the sphere/frustum cull block.
// No dependencies.
package fsc_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned PlaneCountDef = 6;
  localparam int unsigned PlaneIdxW     = 3;

  // Command codes carried on command_i
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdTest  = 1'b1;

  typedef enum logic [1:0] {
    FSC_IDLE,
    FSC_RUN,
    FSC_DRAIN,
    FSC_FIN
  } fsc_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic wr;        // store the plane on the input
    logic start;     // latch sphere, rewind plane counter
    logic issue;     // push the current plane into the MAC pipe
    logic load_out;  // copy verdict into the output register
  } fsc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic last;      // plane counter on the final plane
    logic empty;     // no plane in flight in the MAC pipe
  } fsc_stat_t;

endpackage

// ===== design/fsc_ctrl.sv =====
// Sequencer for the cull block: handshakes, plane issue, drain, output valid.
// Depends on fsc_pkg.
module fsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fsc_pkg::fsc_cmd_t cmd_o,
  input  fsc_pkg::fsc_stat_t stat_i
);

  fsc_pkg::fsc_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fsc_pkg::FSC_IDLE: begin
        if (in_valid_i && (command_i == fsc_pkg::CmdTest)) begin
          state_d = fsc_pkg::FSC_RUN;
        end
      end
      fsc_pkg::FSC_RUN: begin
        if (stat_i.last) begin
          state_d = fsc_pkg::FSC_DRAIN;
        end
      end
      fsc_pkg::FSC_DRAIN: begin
        if (stat_i.empty) begin
          state_d = fsc_pkg::FSC_FIN;
        end
      end
      fsc_pkg::FSC_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = fsc_pkg::FSC_IDLE;
        end
      end
      default: state_d = fsc_pkg::FSC_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      fsc_pkg::FSC_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr    = (command_i == fsc_pkg::CmdWrite);
          cmd_o.start = (command_i == fsc_pkg::CmdTest);
        end
      end
      fsc_pkg::FSC_RUN: begin
        cmd_o.issue = 1'b1;
      end
      fsc_pkg::FSC_DRAIN: begin
        cmd_o = '0;
      end
      fsc_pkg::FSC_FIN: begin
        cmd_o.load_out = !out_valid_q || !out_stall_i;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsc_pkg::FSC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/fsc_dp.sv =====
// Plane store, plane counter and the plane-per-cycle distance pipeline.
// Depends on fsc_pkg.
module fsc_dp #(
  parameter int unsigned PLANE_COUNT = fsc_pkg::PlaneCountDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fsc_pkg::fsc_cmd_t                cmd_i,
  output fsc_pkg::fsc_stat_t               stat_o,
  input  logic [fsc_pkg::PlaneIdxW-1:0]    plane_index_i,
  input  logic signed [fsc_pkg::DataW-1:0] normal_x_i,
  input  logic signed [fsc_pkg::DataW-1:0] normal_y_i,
  input  logic signed [fsc_pkg::DataW-1:0] normal_z_i,
  input  logic signed [fsc_pkg::DataW-1:0] plane_offset_i,
  input  logic signed [fsc_pkg::DataW-1:0] center_x_i,
  input  logic signed [fsc_pkg::DataW-1:0] center_y_i,
  input  logic signed [fsc_pkg::DataW-1:0] center_z_i,
  input  logic signed [fsc_pkg::DataW-1:0] sphere_radius_i,
  output logic                             inside_res_o
);

  localparam int unsigned DW    = fsc_pkg::DataW;
  localparam int unsigned IdxW  = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
  localparam int unsigned ProdW = 2 * DW;
  localparam int unsigned DrW   = DW + 1 + DW / 2;  // (d - r) aligned to Q32.32
  localparam int unsigned SumW  = ProdW + 3;

  logic signed [DW-1:0] nx_q [PLANE_COUNT];
  logic signed [DW-1:0] ny_q [PLANE_COUNT];
  logic signed [DW-1:0] nz_q [PLANE_COUNT];
  logic signed [DW-1:0] d_q  [PLANE_COUNT];

  // plane store; slots reset to zero, and an index at or past PLANE_COUNT matches no slot
  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nx_q[i] <= '0;
        ny_q[i] <= '0;
        nz_q[i] <= '0;
        d_q[i]  <= '0;
      end else if (cmd_i.wr && (32'(plane_index_i) == 32'(i))) begin
        nx_q[i] <= normal_x_i;
        ny_q[i] <= normal_y_i;
        nz_q[i] <= normal_z_i;
        d_q[i]  <= plane_offset_i;
      end
    end
  end

  logic signed [DW-1:0] cx_q, cy_q, cz_q, r_q;
  logic [IdxW-1:0]      cnt_q;
  logic                 ok_q, inside_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      cz_q <= center_z_i;
      r_q  <= sphere_radius_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + IdxW'(1);
    end
  end

  // stage A: three products and the aligned offset term
  logic signed [DW-1:0]    nx_sel, ny_sel, nz_sel, d_sel;
  logic signed [ProdW-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic signed [DrW-1:0]   dr_d, dr_q;

  assign nx_sel = nx_q[cnt_q];
  assign ny_sel = ny_q[cnt_q];
  assign nz_sel = nz_q[cnt_q];
  assign d_sel  = d_q[cnt_q];

  assign px_d = nx_sel * cx_q;
  assign py_d = ny_sel * cy_q;
  assign pz_d = nz_sel * cz_q;
  assign dr_d = (DrW'(d_sel) - DrW'(r_q)) <<< (DW / 2);

  // stage B: sum of the four terms
  logic signed [SumW-1:0] sum_d, sum_q;
  logic                   va_q, vb_q, exceed;

  assign sum_d  = SumW'(px_q) + SumW'(py_q) + SumW'(pz_q) + SumW'(dr_q);
  assign exceed = !sum_q[SumW-1] && (|sum_q);  // distance - radius > 0

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    pz_q  <= pz_d;
    dr_q  <= dr_d;
    sum_q <= sum_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= cmd_i.issue;
      vb_q <= va_q;
    end
  end

  // stage C: fold each plane into the verdict
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ok_q <= 1'b1;
    end else if (vb_q) begin
      ok_q <= ok_q && !exceed;
    end
    if (cmd_i.load_out) begin
      inside_q <= ok_q;
    end
  end

  assign stat_o.last  = (cnt_q == IdxW'(PLANE_COUNT - 1));
  assign stat_o.empty = !va_q && !vb_q;
  assign inside_res_o = inside_q;

endmodule

// ===== design/frustum_sphere_cull_test.sv =====
// Sphere versus frustum cull test, top level.
// Depends on fsc_pkg, fsc_ctrl and fsc_dp.
//
// Holds PLANE_COUNT planes (normal plus offset, signed Q16.16, all zero after
// reset) and tests spheres against them. A write item (command 0) stores one
// plane without stalling the input and returns nothing; an index at or past
// PLANE_COUNT is dropped. A test item (command 1) returns one item:
// inside_res is 0 when some plane gives dot(normal, center) + offset strictly
// above the radius, else 1. The sum is carried exactly at 67 bits, so no
// input pattern wraps or saturates; a negative radius is used as given.
// Timing: one shared multiply-accumulate pipeline (three 32x32 products, a
// four-term adder, a compare) takes one plane per cycle. A test holds the
// input stalled while it issues all PLANE_COUNT planes, drains the pipe and
// loads the result, and the next item is taken once that is done. The result
// sits in an output register; the block goes back to taking items while it
// waits, and only a second finished test stalls behind an unread result.
module frustum_sphere_cull_test #(
  parameter int unsigned PLANE_COUNT = fsc_pkg::PlaneCountDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [fsc_pkg::PlaneIdxW-1:0]    plane_index_i,
  input  logic signed [fsc_pkg::DataW-1:0] normal_x_i,
  input  logic signed [fsc_pkg::DataW-1:0] normal_y_i,
  input  logic signed [fsc_pkg::DataW-1:0] normal_z_i,
  input  logic signed [fsc_pkg::DataW-1:0] plane_offset_i,
  input  logic signed [fsc_pkg::DataW-1:0] center_x_i,
  input  logic signed [fsc_pkg::DataW-1:0] center_y_i,
  input  logic signed [fsc_pkg::DataW-1:0] center_z_i,
  input  logic signed [fsc_pkg::DataW-1:0] sphere_radius_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             inside_res_o
);

  fsc_pkg::fsc_cmd_t  cmd;
  fsc_pkg::fsc_stat_t stat;

  // sequencer: owns both handshakes and the output valid
  fsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // plane store and distance pipeline
  fsc_dp #(
    .PLANE_COUNT (PLANE_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .plane_index_i   (plane_index_i),
    .normal_x_i      (normal_x_i),
    .normal_y_i      (normal_y_i),
    .normal_z_i      (normal_z_i),
    .plane_offset_i  (plane_offset_i),
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .sphere_radius_i (sphere_radius_i),
    .inside_res_o    (inside_res_o)
  );

endmodule

// ===== design/fsc_checker.sv =====
// Port-level checks for the cull block, bound to the top level.
// Depends on fsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fsc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          command_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          inside_res_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result item holds
  `ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(inside_res_o))

  // a test keeps the input stalled while planes are evaluated
  `ASSERT_NEXT(a_test_busy, in_acc && (command_i == fsc_pkg::CmdTest), in_stall_o)

  // a plane write finishes in the cycle it is taken
  `ASSERT_NEXT(a_write_fast, in_acc && (command_i == fsc_pkg::CmdWrite), !in_stall_o)

  // a new result appears only at the end of a busy stretch
  `ASSERT_SAME(a_res_after_busy, $rose(out_valid_o), $past(in_stall_o))

endmodule

bind frustum_sphere_cull_test fsc_checker u_fsc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for frustum_sphere_cull_test: plane writes and sphere tests are
// checked, result by result, against a wide-integer plane-distance predictor.
// Depends on fsc_pkg and the frustum_sphere_cull_test RTL.
module testbench;

  localparam int unsigned DataW      = fsc_pkg::DataW;
  localparam int unsigned PlaneIdxW  = fsc_pkg::PlaneIdxW;
  localparam int unsigned NumPlanes  = fsc_pkg::PlaneCountDef;
  localparam int unsigned CycleLimit = 600_000;
  localparam int unsigned DrainWait  = 20;
  localparam int unsigned MaxReports = 100;
  localparam int unsigned HoldOff    = 400;

  // Plane slots, in the order load_box writes the faces; the block treats all slots alike.
  localparam logic [PlaneIdxW-1:0] PlaneLeft  = 3'd0;
  localparam logic [PlaneIdxW-1:0] PlaneRight = 3'd1;
  localparam logic [PlaneIdxW-1:0] PlaneDown  = 3'd2;
  localparam logic [PlaneIdxW-1:0] PlaneUp    = 3'd3;
  localparam logic [PlaneIdxW-1:0] PlaneNear  = 3'd4;
  localparam logic [PlaneIdxW-1:0] PlaneFar   = 3'd5;

  // Q16.16 landmarks
  localparam logic signed [DataW-1:0] QOne = 32'sh0001_0000;
  localparam logic signed [DataW-1:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] QMin = 32'sh8000_0000;

  // One item on the input channel. Fields a command does not use still carry
  // random content, so the block must ignore them.
  typedef struct {
    logic                    cmd;
    logic [PlaneIdxW-1:0]    idx;
    logic signed [DataW-1:0] nx, ny, nz, d;
    logic signed [DataW-1:0] cx, cy, cz, r;
  } cull_item_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    command_i;
  logic [PlaneIdxW-1:0]    plane_index_i;
  logic signed [DataW-1:0] normal_x_i, normal_y_i, normal_z_i, plane_offset_i;
  logic signed [DataW-1:0] center_x_i, center_y_i, center_z_i, sphere_radius_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    inside_res_o;

  frustum_sphere_cull_test dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .plane_index_i  (plane_index_i),
    .normal_x_i     (normal_x_i),
    .normal_y_i     (normal_y_i),
    .normal_z_i     (normal_z_i),
    .plane_offset_i (plane_offset_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .center_z_i     (center_z_i),
    .sphere_radius_i(sphere_radius_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .inside_res_o   (inside_res_o)
  );

  // 20 ns clock
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the plane store and the verdicts it implies.
  // ---------------------------------------------------------------------------
  logic signed [DataW-1:0] pl_nx[NumPlanes];
  logic signed [DataW-1:0] pl_ny[NumPlanes];
  logic signed [DataW-1:0] pl_nz[NumPlanes];
  logic signed [DataW-1:0] pl_d[NumPlanes];

  logic        contained_expected[$];  // verdicts of accepted tests, oldest first
  int unsigned items_taken, writes_taken, tests_taken;
  int unsigned results_seen, contained_seen;
  int unsigned fail_count;
  int unsigned cycle_count;

  // Sender/receiver knobs, flipped by the test tasks.
  bit          tx_idle_on;
  bit          rx_idle_on;
  int unsigned hold_off_cycles;
  int unsigned box_half;  // half width of the current box frustum, whole units

  // Distance of the center to each plane, carried exactly: three Q32.32
  // products plus (offset - radius) moved up to Q32.32. 80 bits is plenty
  // for the 65 the sum can need. Any plane strictly beyond the radius culls.
  function automatic logic sphere_contained(input logic signed [DataW-1:0] cx, cy, cz, r);
    logic signed [79:0] plane_dist;
    for (int p = 0; p < NumPlanes; p++) begin
      plane_dist = pl_nx[p] * cx;
      plane_dist = plane_dist + pl_ny[p] * cy + pl_nz[p] * cz;
      plane_dist = plane_dist + ((pl_d[p] - r) <<< 16);
      if (plane_dist > 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Called once per accepted item, in acceptance order.
  function automatic void apply_item(input cull_item_t it);
    items_taken++;
    if (it.cmd == fsc_pkg::CmdWrite) begin
      writes_taken++;
      // writes past the last plane slot are dropped by the block
      if (it.idx < NumPlanes) begin
        pl_nx[it.idx] = it.nx;
        pl_ny[it.idx] = it.ny;
        pl_nz[it.idx] = it.nz;
        pl_d[it.idx]  = it.d;
      end
    end else begin
      tests_taken++;
      contained_expected.push_back(sphere_contained(it.cx, it.cy, it.cz, it.r));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic logic signed [DataW-1:0] rand_span(input int unsigned span);
    return int'($urandom_range(0, 2 * span)) - int'(span);
  endfunction

  function automatic cull_item_t noise_item();
    cull_item_t it;
    it.cmd = 1'($urandom_range(0, 1));
    it.idx = PlaneIdxW'($urandom_range(0, 7));
    it.nx  = $urandom;
    it.ny  = $urandom;
    it.nz  = $urandom;
    it.d   = $urandom;
    it.cx  = $urandom;
    it.cy  = $urandom;
    it.cz  = $urandom;
    it.r   = $urandom;
    return it;
  endfunction

  function automatic cull_item_t make_write(input logic [PlaneIdxW-1:0] idx,
                                            input logic signed [DataW-1:0] nx, ny, nz, d);
    cull_item_t it;
    it     = noise_item();
    it.cmd = fsc_pkg::CmdWrite;
    it.idx = idx;
    it.nx  = nx;
    it.ny  = ny;
    it.nz  = nz;
    it.d   = d;
    return it;
  endfunction

  function automatic cull_item_t make_test(input logic signed [DataW-1:0] cx, cy, cz, r);
    cull_item_t it;
    it     = noise_item();
    it.cmd = fsc_pkg::CmdTest;
    it.cx  = cx;
    it.cy  = cy;
    it.cz  = cz;
    it.r   = r;
    return it;
  endfunction

  // Sphere scattered around the current box, reaching out to twice its size so
  // that both verdicts come up often. Now and then the radius is negative.
  function automatic cull_item_t box_sphere();
    int unsigned             span;
    logic signed [DataW-1:0] r;
    span = (2 * box_half) << 16;
    if ($urandom_range(0, 9) == 0) r = -int'($urandom_range(0, box_half << 16));
    else r = $urandom_range(0, box_half << 16);
    return make_test(rand_span(span), rand_span(span), rand_span(span), r);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: inputs change on the falling edge, acceptance is seen on the
  // rising edge. Valid stays high from one item to the next unless a gap is
  // drawn, and a gap lowers it on a different edge from the one that raises it.
  // ---------------------------------------------------------------------------
  task automatic drive_payload(input cull_item_t it);
    command_i       = it.cmd;
    plane_index_i   = it.idx;
    normal_x_i      = it.nx;
    normal_y_i      = it.ny;
    normal_z_i      = it.nz;
    plane_offset_i  = it.d;
    center_x_i      = it.cx;
    center_y_i      = it.cy;
    center_z_i      = it.cz;
    sphere_radius_i = it.r;
  endtask

  task automatic send_item(input cull_item_t it);
    int unsigned gap;
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap        = $urandom_range(1, 13);
      in_valid_i = 1'b0;
      drive_payload(noise_item());  // junk while valid is low
      repeat (gap) @(negedge clk_i);
    end
    drive_payload(it);
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    apply_item(it);
  endtask

  // Six axis planes bounding a cube of the given half width. With tilt the
  // normals and offsets are nudged by up to a quarter and one unit.
  task automatic load_box(input int unsigned half_units, input bit tilt);
    logic signed [DataW-1:0] n[3];
    logic signed [DataW-1:0] d;
    box_half = half_units;
    for (int p = 0; p < NumPlanes; p++) begin
      n[0] = '0;
      n[1] = '0;
      n[2] = '0;
      n[p / 2] = (p % 2 != 0) ? QOne : -QOne;  // left/down/near face the minus side
      d = -int'(half_units << 16);
      if (tilt) begin
        for (int k = 0; k < 3; k++) n[k] = n[k] + rand_span(QOne / 4);
        d = d + rand_span(QOne);
      end
      send_item(make_write(PlaneIdxW'(p), n[0], n[1], n[2], d));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts, plus a long hold-off on request. The
  // hold-off is counted here, in cycles, while the sender keeps offering.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned run_len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        run_len         = hold_off_cycles;
        hold_off_cycles = 0;
        out_stall_i     = 1'b1;
        repeat (run_len - 1) @(negedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Each taken result is matched against the oldest waiting verdict.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (contained_expected.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t: result with nothing expected: expected none, actual inside_res=%0b",
                   $time, inside_res_o);
      end else begin
        results_seen++;
        if (inside_res_o === 1'b1) contained_seen++;
        if (inside_res_o !== contained_expected[0]) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("%0t: inside_res mismatch: expected %0b, actual %0b (result %0d)",
                     $time, contained_expected[0], inside_res_o, results_seen);
        end
        void'(contained_expected.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts still waiting",
               $time, cycle_count, contained_expected.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset every plane is zero, so only the radius sign matters.
  task automatic test_empty_frustum();
    send_item(make_test($urandom, $urandom, $urandom, '0));
    send_item(make_test($urandom, $urandom, $urandom, -32'sd1));
    send_item(make_test($urandom, $urandom, $urandom, QMax));
  endtask

  // Writes past the last slot must not land anywhere; a plane with offset
  // QMax would cull everything at radius zero.
  task automatic test_dropped_index();
    send_item(make_write(PlaneIdxW'(NumPlanes), '0, '0, '0, QMax));
    send_item(make_write('1, QMin, QMin, QMin, QMax));
    send_item(make_test('0, '0, '0, '0));
  endtask

  // Full-scale normals, centers, offsets and radii, where the distance sum
  // needs 65 of its 67 bits; also the radius exactly at and one lsb under it.
  task automatic test_extreme_values();
    send_item(make_write(PlaneLeft, QMin, QMin, QMin, QMax));
    send_item(make_test(QMin, QMin, QMin, QMin));
    send_item(make_test(QMax, QMax, QMax, QMax));
    send_item(make_test('0, '0, '0, QMax));
    send_item(make_test('0, '0, '0, QMax - 32'sd1));
    send_item(make_write(PlaneFar, QMax, QMax, QMax, QMin));
    send_item(make_test(QMax, QMax, QMax, QMin));
  endtask

  // A 20-unit cube: clear inside, clear outside, tangent (kept), one lsb
  // past tangent (culled), and negative radii either side of the offset.
  task automatic test_box_boundaries();
    load_box(10, 1'b0);
    send_item(make_test('0, '0, '0, QOne));
    send_item(make_test(20 * QOne, '0, '0, 5 * QOne));
    send_item(make_test('0, '0, 12 * QOne, 2 * QOne));
    send_item(make_test('0, -12 * QOne, '0, 2 * QOne - 32'sd1));
    send_item(make_test('0, '0, '0, -5 * QOne));
    send_item(make_test('0, '0, '0, -15 * QOne));
  endtask

  // Full-range noise mixed with box reloads and spheres around the box.
  task automatic test_random_mix(input int unsigned target);
    cull_item_t it;
    while (items_taken < target) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          it     = noise_item();
          it.cmd = fsc_pkg::CmdWrite;
          send_item(it);
        end
        3: load_box($urandom_range(1, 1000), 1'($urandom_range(0, 1)));
        4, 5, 6: begin
          it     = noise_item();
          it.cmd = fsc_pkg::CmdTest;
          send_item(it);
        end
        default: send_item(box_sphere());
      endcase
    end
  endtask

  // Well-formed scenes: load a frustum, then a run of spheres against it.
  task automatic test_box_scenes(input int unsigned target);
    while (items_taken < target) begin
      load_box($urandom_range(1, 1000), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(20, 60)) send_item(box_sphere());
    end
  endtask

  // Receiver holds off for a long stretch while tests keep coming: the
  // output register fills, the next test finishes behind it and the input
  // stalls until the hold ends.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    load_box(50, 1'b1);
    hold_off_cycles = HoldOff;
    repeat (40) send_item(box_sphere());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Closing stretch at full rate, no gaps on either side.
  task automatic test_full_rate(input int unsigned target);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_mix(items_taken + (target - items_taken) / 3);
    test_box_scenes(target);
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    hold_off_cycles = 0;
    box_half        = 1;
    drive_payload(noise_item());
    for (int p = 0; p < NumPlanes; p++) begin
      pl_nx[p] = '0;
      pl_ny[p] = '0;
      pl_nz[p] = '0;
      pl_d[p]  = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_frustum();
    test_dropped_index();
    test_extreme_values();
    test_box_boundaries();
    test_random_mix(520);
    test_box_scenes(1300);
    test_output_backpressure();
    test_full_rate(1720);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (contained_expected.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Covered %0d plane writes and %0d sphere tests in %0d cycles;",
             writes_taken, tests_taken, cycle_count);
    $display("%0d verdicts checked: %0d contained, %0d culled, %0d failures.",
             results_seen, contained_seen, results_seen - contained_seen, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
